// File: hdl/depth_tile_nearest_object_assert.svh
// Assertion macros for the depth tile block
`ifndef DEPTH_TILE_NEAREST_OBJECT_ASSERT_SVH
`define DEPTH_TILE_NEAREST_OBJECT_ASSERT_SVH

// implication checked on every edge outside reset
`define DT_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define DT_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// File: hdl/dtno_pkg.sv
package dtno_pkg;
	localparam int MaxWidth   = 256;
	localparam int MaxHeight  = 256;
	localparam int Bins       = 256;
	localparam int Window     = 50;
	localparam int Tiles      = 9;
	localparam int HistDepth  = Tiles * Bins;
	localparam int HistAw     = $clog2(HistDepth);
	localparam int CountW     = 17;
	localparam logic [CountW-1:0] CountMax = '1;
	localparam logic [7:0] ScanStart   = 8'd17;
	localparam logic [7:0] BinMinCount = 8'd5;
	localparam logic [7:0] ValidConf   = 8'd10;
	localparam logic [7:0] GreyInvalid = 8'd230;
	localparam logic [7:0] GreyFar     = 8'd255;

	localparam logic [1:0] RegMaxDepth  = 2'd0;
	localparam logic [1:0] RegMinObject = 2'd1;
	localparam logic [1:0] RegWidth     = 2'd2;
	localparam logic [1:0] RegHeight    = 2'd3;

	typedef struct packed {
		logic [15:0] depth_mm;
		logic [7:0]  confidence;
	} pixel_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic [3:0] tile;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [15:0] data;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;
endpackage

// File: hdl/dtno_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
module dtno_divider (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dtno_pkg::div_req_t       req,
	output logic                     done,
	output logic [23:0]              quotient
);
	import dtno_pkg::*;

	logic [23:0] quo_q;
	logic [16:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [15:0] den_q;
	logic [16:0] trial;
	logic [17:0] diff;

	assign trial = {rem_q[15:0], quo_q[23]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd24;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend[23:0];
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[17]) begin
				rem_q <= diff[16:0];
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

// File: hdl/depth_tile_nearest_object.sv
// Channel  | Signals                              | Dir | Handshake
// request  | start, busy, pixel                   | in  | start && !busy
// result   | result_valid, result                 | out | one-cycle strobe
// config   | cfg_valid, cfg_ready, cfg            | in  | valid && ready
// Reset runs a clearing pass over the 2304-entry histogram, one entry a cycle,
// with busy high. A pixel is accepted in idle, waits in StDiv on the 24-step
// divider, then passes StRd, StRdW and StWr for the histogram read-modify-write;
// its grey result is registered in StWr, and the next pixel is taken only in idle.
// The last pixel of a frame adds a scan of 9 tiles x 239 bins, each bin through
// StScanA, StScanW, StScanB, StScanC and StScanD, plus StEmit per tile, then
// another clearing pass. Results cannot be stalled.
module depth_tile_nearest_object (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  dtno_pkg::pixel_t    pixel,
	output logic                result_valid,
	output dtno_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  dtno_pkg::cfg_t      cfg
);
	import dtno_pkg::*;

	localparam logic [3:0] StClear = 4'd0;
	localparam logic [3:0] StIdle  = 4'd1;
	localparam logic [3:0] StDiv   = 4'd2;
	localparam logic [3:0] StRd    = 4'd3;
	localparam logic [3:0] StRdW   = 4'd4;
	localparam logic [3:0] StWr    = 4'd5;
	localparam logic [3:0] StScanA = 4'd6;
	localparam logic [3:0] StScanW = 4'd7;
	localparam logic [3:0] StScanB = 4'd8;
	localparam logic [3:0] StScanC = 4'd9;
	localparam logic [3:0] StScanD = 4'd10;
	localparam logic [3:0] StEmit  = 4'd11;

	logic [3:0]  state_q;
	logic [15:0] max_depth_q, min_obj_q;
	logic [8:0]  width_q, height_q;
	logic [8:0]  column_q, row_q;
	logic [15:0] depth_q;
	logic        valid_px_q;
	logic [3:0]  tile_q;
	logic [7:0]  grey_q;
	logic [HistAw-1:0] clr_q;
	logic [3:0]  scan_tile_q;
	logic [7:0]  bin_q;
	logic [17:0] window_sum_q;
	logic [7:0]  found_q;
	logic        hit_q;
	logic [CountW-1:0] add_q;

	logic [CountW-1:0] hist_mem [HistDepth];
	logic [CountW-1:0] rd_data_q;
	logic [HistAw-1:0] rd_addr, wr_addr;
	logic [CountW-1:0] wr_data;
	logic              wr_en;

	div_req_t    div_req;
	logic        div_done;
	logic [23:0] div_quo;

	logic [8:0]  w_eff, h_eff;
	logic [7:0]  tw, th;
	logic [1:0]  tcol, trow;
	logic [3:0]  tile_now;

	dtno_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		w_eff = (width_q < 9'd3) ? 9'd3 : width_q;
		h_eff = (height_q < 9'd3) ? 9'd3 : height_q;
		if (width_q > 9'(MaxWidth)) w_eff = 9'(MaxWidth);
		if (height_q > 9'(MaxHeight)) h_eff = 9'(MaxHeight);
		// tile span w/3+1 via reciprocal: (w*171)>>9 is exact for w <= 256
		tw = 8'((18'(w_eff) * 18'd171) >> 9) + 8'd1;
		th = 8'((18'(h_eff) * 18'd171) >> 9) + 8'd1;
		if ({1'b0, column_q} >= {2'b00, tw} + {2'b00, tw}) tcol = 2'd2;
		else if (column_q >= {1'b0, tw}) tcol = 2'd1;
		else tcol = 2'd0;
		if ({1'b0, row_q} >= {2'b00, th} + {2'b00, th}) trow = 2'd2;
		else if (row_q >= {1'b0, th}) trow = 2'd1;
		else trow = 2'd0;
		tile_now = 4'(tcol) + 4'(trow) * 4'd3;
	end

	assign busy      = (state_q != StIdle);
	assign cfg_ready = 1'b1;

	assign div_req.start    = (state_q == StIdle) && start;
	assign div_req.dividend = 32'(pixel.depth_mm) * 32'd255;
	assign div_req.divisor  = max_depth_q;

	always_comb begin
		rd_addr = HistAw'(tile_q) * HistAw'(Bins) + HistAw'(grey_q);
		if (state_q == StScanA) rd_addr = HistAw'(scan_tile_q) * HistAw'(Bins) + HistAw'(bin_q);
		if (state_q == StScanB)
			rd_addr = HistAw'(scan_tile_q) * HistAw'(Bins) + HistAw'(bin_q - 8'(Window));
		wr_en   = (state_q == StClear) || (state_q == StWr);
		wr_addr = (state_q == StClear) ? clr_q : rd_addr;
		wr_data = (state_q == StClear) ? '0
			: (rd_data_q == CountMax) ? rd_data_q : rd_data_q + CountW'(1);
	end

	always_ff @(posedge clk) begin
		if (wr_en) hist_mem[wr_addr] <= wr_data;
		rd_data_q <= hist_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StClear;
			max_depth_q <= 16'd1500;
			min_obj_q   <= 16'd90;
			width_q     <= 9'd224;
			height_q    <= 9'd171;
			column_q    <= '0;
			row_q       <= '0;
			clr_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_valid) begin
				case (cfg.index)
					RegMaxDepth:  max_depth_q <= cfg.data;
					RegMinObject: min_obj_q   <= cfg.data;
					RegWidth:     width_q     <= cfg.data[8:0];
					RegHeight:    height_q    <= cfg.data[8:0];
					default: ;
				endcase
			end
			case (state_q)
				StClear: begin
					clr_q <= clr_q + HistAw'(1);
					if (clr_q == HistAw'(HistDepth - 1)) begin
						clr_q   <= '0;
						state_q <= StIdle;
					end
				end
				StIdle: if (start) begin
					depth_q    <= pixel.depth_mm;
					valid_px_q <= pixel.confidence > ValidConf;
					tile_q     <= tile_now;
					state_q    <= StDiv;
				end
				StDiv: if (div_done) begin
					if (!valid_px_q) grey_q <= GreyFar;
					else if (max_depth_q == '0 || depth_q > max_depth_q) grey_q <= GreyFar;
					else grey_q <= div_quo[7:0];
					state_q <= StRd;
				end
				StRd: state_q <= StRdW;
				StRdW: state_q <= StWr;
				StWr: begin
					result_valid  <= 1'b1;
					result.kind   <= 1'b0;
					result.value  <= valid_px_q ? grey_q : GreyInvalid;
					result.tile   <= '0;
					result.last   <= 1'b0;
					state_q       <= StIdle;
					if ({1'b0, column_q} + 10'd1 >= {1'b0, w_eff}) begin
						column_q <= '0;
						if ({1'b0, row_q} + 10'd1 >= {1'b0, h_eff}) begin
							row_q       <= '0;
							scan_tile_q <= '0;
							bin_q       <= ScanStart;
							window_sum_q <= '0;
							hit_q       <= 1'b0;
							state_q     <= StScanA;
						end else begin
							row_q <= row_q + 9'd1;
						end
					end else begin
						column_q <= column_q + 9'd1;
					end
				end
				// read entering bin, then leaving bin, and update the window
				StScanA: state_q <= StScanW;
				StScanW: begin
					add_q   <= (rd_data_q > CountW'(BinMinCount)) ? rd_data_q : '0;
					state_q <= StScanB;
				end
				StScanB: state_q <= StScanC;
				StScanC: begin
					if (bin_q >= ScanStart + 8'(Window) && rd_data_q > CountW'(BinMinCount))
						window_sum_q <= window_sum_q + 18'(add_q) - 18'(rd_data_q);
					else
						window_sum_q <= window_sum_q + 18'(add_q);
					state_q <= StScanD;
				end
				StScanD: begin
					if (!hit_q && window_sum_q >= 18'(min_obj_q)) begin
						hit_q   <= 1'b1;
						found_q <= bin_q;
					end
					if (bin_q == 8'd255) state_q <= StEmit;
					else begin
						bin_q   <= bin_q + 8'd1;
						state_q <= StScanA;
					end
				end
				StEmit: begin
					result_valid <= 1'b1;
					result.kind  <= 1'b1;
					result.value <= hit_q ? 8'd255 - found_q : 8'd255;
					result.tile  <= 4'd8 - scan_tile_q;
					result.last  <= (scan_tile_q == 4'd8);
					bin_q        <= ScanStart;
					window_sum_q <= '0;
					hit_q        <= 1'b0;
					scan_tile_q  <= scan_tile_q + 4'd1;
					if (scan_tile_q == 4'd8) begin
						state_q     <= StClear;
					end else state_q <= StScanA;
				end
				default: state_q <= StClear;
			endcase
		end
	end

	`include "depth_tile_nearest_object_assert.svh"

	`DT_ASSERT_IMP(a_no_strobe_idle, state_q == StIdle, !result_valid || !result.kind)
	`DT_ASSERT_IMP(a_last_is_tile8, result_valid && result.last,
		result.kind && result.tile == '0)
	`DT_ASSERT_NEXT(a_last_clears, result_valid && result.last, state_q == StClear)
endmodule

// File: tb/depth_tile_nearest_object_tb.sv
module depth_tile_nearest_object_tb;
	import dtno_pkg::*;

	localparam logic KindGrey     = 1'b0;
	localparam logic KindStrength = 1'b1;
	localparam int   CycleLimit   = 1000000;
	localparam int   SettleCycles = 60;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	pixel_t  pixel = '0;
	logic    result_valid;
	result_t result;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	cfg_t    cfg = '0;

	depth_tile_nearest_object uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.result_valid(result_valid), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg(cfg)
	);

	always #5 clk = ~clk;

	// predictor state
	int unsigned hist [Tiles][Bins];
	int unsigned col_pos, row_pos;
	int unsigned max_depth, min_object, width_reg, height_reg;

	pixel_t  pending_pixels [$];
	result_t awaited_results [$];
	int      sent_count = 0;
	int      taken_count = 0;
	int      gap_left = 0;
	int      cycle_count = 0;
	bit      failed = 1'b0;

	function automatic int unsigned clamp_size(int unsigned v);
		if (v < 3) return 3;
		if (v > 256) return 256;
		return v;
	endfunction

	function automatic int unsigned nearest_bin(int t);
		int unsigned sum;
		int unsigned c;
		sum = 0;
		for (int i = ScanStart; i < Bins; i++) begin
			c = hist[t][i];
			if (c > BinMinCount) sum += c;
			if (i >= ScanStart + Window) begin
				c = hist[t][i - Window];
				if (c > BinMinCount) sum -= c;
			end
			if (sum >= min_object) return i;
		end
		return 0;
	endfunction

	task automatic predict_pixel(pixel_t p);
		int unsigned w, h, tcol, trow, t, grey, bin;
		result_t r;
		w = clamp_size(width_reg);
		h = clamp_size(height_reg);
		tcol = col_pos / (w / 3 + 1);
		trow = row_pos / (h / 3 + 1);
		if (tcol > 2) tcol = 2;
		if (trow > 2) trow = 2;
		t = tcol + 3 * trow;
		if (p.confidence <= ValidConf) begin
			grey = GreyInvalid;
			bin = GreyFar;
		end else begin
			if (max_depth == 0 || p.depth_mm > max_depth) grey = GreyFar;
			else grey = (p.depth_mm * 255) / max_depth;
			bin = grey;
		end
		if (hist[t][bin] < CountMax) hist[t][bin]++;
		r.kind = KindGrey;
		r.value = grey[7:0];
		r.tile = '0;
		r.last = 1'b0;
		awaited_results.push_back(r);
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h) begin
				row_pos = 0;
				for (int k = 0; k < Tiles; k++) begin
					bin = nearest_bin(k);
					r.kind = KindStrength;
					r.value = 8'(255 - bin);
					r.tile = 4'(8 - k);
					r.last = (k == Tiles - 1);
					awaited_results.push_back(r);
				end
				foreach (hist[i, j]) hist[i][j] = 0;
			end
		end
	endtask

	// driver: hold a request until it is taken, then idle or send the next one
	always @(negedge clk) begin
		if (arst_n && !(start && taken_count != sent_count)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_pixels.size() > 0) begin
				pixel <= pending_pixels.pop_front();
				start <= 1'b1;
				sent_count <= sent_count + 1;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: gap_left <= 0;
					6, 7, 8: gap_left <= $urandom_range(1, 3);
					default: gap_left <= $urandom_range(10, 60);
				endcase
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (cycle_count > CycleLimit) begin
				$display("depth_tile_nearest_object: mismatch");
				$finish;
			end
			if (result_valid) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result %p", result);
					failed = 1'b1;
				end else begin
					e = awaited_results.pop_front();
					if (result.kind !== e.kind) begin
						$error("kind: expected %0d actual %0d", e.kind, result.kind);
						failed = 1'b1;
					end
					if (result.value !== e.value) begin
						$error("value: expected %0d actual %0d", e.value, result.value);
						failed = 1'b1;
					end
					if (result.tile !== e.tile) begin
						$error("tile: expected %0d actual %0d", e.tile, result.tile);
						failed = 1'b1;
					end
					if (result.last !== e.last) begin
						$error("last: expected %0d actual %0d", e.last, result.last);
						failed = 1'b1;
					end
				end
			end
			if (start && !busy) begin
				taken_count <= taken_count + 1;
				predict_pixel(pixel);
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg <= '{index: idx, data: data};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			RegMaxDepth:  max_depth = data;
			RegMinObject: min_object = data;
			RegWidth:     width_reg = data[8:0];
			RegHeight:    height_reg = data[8:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		wait (pending_pixels.size() == 0 && sent_count == taken_count
			&& awaited_results.size() == 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic push(int unsigned d, int unsigned c);
		pending_pixels.push_back('{depth_mm: 16'(d), confidence: 8'(c)});
	endtask

	initial begin
		int unsigned w, h, base, spread, random_items;
		foreach (hist[i, j]) hist[i][j] = 0;
		col_pos = 0;
		row_pos = 0;
		max_depth = 1500;
		min_object = 90;
		width_reg = 224;
		height_reg = 171;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// 3x3 frame, zero object size: every tile reports the first scanned bin
		write_reg(RegMaxDepth, 16'd1500);
		write_reg(RegMinObject, 16'd0);
		write_reg(RegWidth, 16'd3);
		write_reg(RegHeight, 16'd3);
		push(0, 255); push(65535, 255); push(1500, 11);
		push(1501, 200); push(749, 11); push(1000, 10);
		push(0, 0); push(65535, 0); push(3, 128);
		wait_drained();

		// zero range, oversize width register, undersize height register
		write_reg(RegMaxDepth, 16'd0);
		write_reg(RegMinObject, 16'd65535);
		write_reg(RegWidth, 16'd511);
		write_reg(RegHeight, 16'd0);
		for (int i = 0; i < 10; i++) push(i * 7000, (i % 2) ? 5 : 250);
		wait_drained();
		// shrink the width mid-row: position wraps, tile column clamps
		write_reg(RegWidth, 16'd3);
		for (int i = 0; i < 7; i++) push(i * 9000, 11 + i);
		wait_drained();

		random_items = 0;
		while (random_items < 100) begin
			w = $urandom_range(3, 12);
			h = $urandom_range(3, 12);
			case ($urandom_range(0, 5))
				0: write_reg(RegMaxDepth, 16'hFFFF);
				default: write_reg(RegMaxDepth, 16'($urandom_range(1, 5000)));
			endcase
			case ($urandom_range(0, 7))
				0: write_reg(RegMinObject, 16'd0);
				1: write_reg(RegMinObject, 16'hFFFF);
				default: write_reg(RegMinObject, 16'($urandom_range(1, 40)));
			endcase
			write_reg(RegWidth, 16'(w));
			write_reg(RegHeight, 16'(h));
			base = $urandom_range(0, max_depth + max_depth / 4);
			spread = $urandom_range(0, max_depth / 20 + 1);
			for (int i = 0; i < w * h; i++) begin
				if ($urandom_range(0, 4) != 0) begin
					push((base + $urandom_range(0, spread) > 65535) ? 65535
						: base + $urandom_range(0, spread), $urandom_range(11, 255));
				end else begin
					push($urandom, $urandom_range(0, 255));
				end
			end
			random_items += w * h;
			wait_drained();
		end

		if (!failed) begin
			$display("depth_tile_nearest_object: match");
		end else begin
			$display("depth_tile_nearest_object: mismatch");
		end
		$finish;
	end
endmodule
